### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the scaled weight matrix engine.
// No dependencies; the including scope provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked on every rising edge outside reset.
`define SWME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define SWME_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### rtl/swme_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers for the scaled weight matrix engine.
// No dependencies.
package swme_pkg;

  localparam int NUM_DIMS    = 1024;
  localparam int NUM_CLASSES = 8;
  localparam int DEPTH       = NUM_DIMS * NUM_CLASSES;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam logic [CLS_W-1:0]  K_LAST   = CLS_W'(NUM_CLASSES - 1);
  localparam logic [ADDR_W-1:0] ADDR_END = ADDR_W'(DEPTH - 1);

  localparam int MODE_W = 3;
  localparam int ROW_W  = 20;
  localparam int SEL_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [31:0]        SCALE_ONE     = 32'h4000_0000;
  localparam logic [31:0]        MIN_SCALE_RST = 32'd1073742;
  localparam logic signed [31:0] BIAS_RST      = 32'sd16777216;

  // input modes
  localparam logic [MODE_W-1:0] MD_SCORE    = 3'd0;
  localparam logic [MODE_W-1:0] MD_UPD_ALL  = 3'd1;
  localparam logic [MODE_W-1:0] MD_UPD_ONE  = 3'd2;
  localparam logic [MODE_W-1:0] MD_SET_COEF = 3'd3;
  localparam logic [MODE_W-1:0] MD_DECAY    = 3'd4;
  localparam logic [MODE_W-1:0] MD_CLEAR    = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_VALUE = 2'd1;

  typedef enum logic [1:0] {SW_32, SW_40, SW_48} satw_t;

  typedef enum logic [1:0] {MP_IDLE, MP_LO, MP_HI, MP_RND} mul_ph_t;
  typedef enum logic [1:0] {DP_IDLE, DP_RUN, DP_RND} div_ph_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISP,
    ST_SC_RD, ST_SC_MUL, ST_SC_ACC,
    ST_SO_MUL, ST_SO_WAIT, ST_SO_EMIT,
    ST_UP_RD, ST_UP_MUL, ST_UP_PROD, ST_UP_DIV,
    ST_IC_MUL, ST_IC_WAIT,
    ST_DC_SMUL, ST_DC_SWAIT, ST_DC_IMUL, ST_DC_IWAIT,
    ST_FD_RD, ST_FD_MUL, ST_FD_WAIT
  } st_t;

  typedef struct packed {
    logic        start;
    logic [47:0] a;      // magnitude
    logic [31:0] b;      // magnitude
    logic        neg;
    logic        sh30;   // 1: shift 30, 0: shift 24
    satw_t       wsel;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic               busy;
    logic signed [47:0] res;
    logic [63:0]        prod;  // raw magnitude product, valid after done
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [62:0] m;
    logic [31:0] s;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        busy;
    logic [40:0] q;
  } div_rsp_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  function automatic logic [47:0] mag48(input logic signed [47:0] x);
    return x[47] ? 48'(-x) : 48'(x);
  endfunction

  function automatic logic signed [47:0] sat_add48(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
    logic signed [48:0] s;
    s = 49'(a) + 49'(b);
    if (s[48] != s[47]) return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    return s[47:0];
  endfunction

  function automatic logic signed [31:0] sat_w32(input logic signed [42:0] x);
    if (x > 43'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -43'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

endpackage

### rtl/swme_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input item, result item, register write.
// Depends on swme_pkg.
interface swme_in_if;
  logic                          valid;
  logic                          ready;
  logic [swme_pkg::MODE_W-1:0]   mode;
  logic [swme_pkg::ROW_W-1:0]    feature_index;
  logic signed [31:0]            feature_value;
  logic                          masked;
  logic [swme_pkg::SEL_W-1:0]    class_sel;
  logic signed [31:0]            coeff;
  logic                          last_element;
  modport source (output valid, mode, feature_index, feature_value, masked, class_sel,
                  coeff, last_element, input ready);
  modport sink (input valid, mode, feature_index, feature_value, masked, class_sel,
                coeff, last_element, output ready);
endinterface

interface swme_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] score;
  logic [2:0]         class_index;
  logic               last_score;
  modport source (output valid, score, class_index, last_score, input ready);
  modport sink (input valid, score, class_index, last_score, output ready);
endinterface

interface swme_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swme_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/swme_ram.sv
`timescale 1ns / 1ps
// Weight store: single-write, single-read RAM with registered read data.
// Depends on swme_pkg.
module swme_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic                          re,
  input  logic [swme_pkg::ADDR_W-1:0]   addr,
  input  logic signed [31:0]            wdata,
  output logic signed [31:0]            rdata
);

  logic signed [31:0] mem [swme_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/swme_mul.sv
`timescale 1ns / 1ps
// Shared multiplier: 48x32 magnitude product in two 32x32 passes, then round/shift/saturate.
// Depends on swme_pkg.
module swme_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  swme_pkg::mul_req_t req,
  output swme_pkg::mul_rsp_t rsp
);

  swme_pkg::mul_ph_t ph_r, ph_nxt;
  logic               done_r, done_nxt;
  logic [47:0]        a_r, a_nxt;
  logic [31:0]        b_r, b_nxt;
  logic               neg_r, neg_nxt;
  logic               sh30_r, sh30_nxt;
  swme_pkg::satw_t    wsel_r, wsel_nxt;
  logic [79:0]        acc_r, acc_nxt;
  logic signed [47:0] res_r, res_nxt;

  logic [31:0] mop;
  logic [63:0] pp;
  logic [80:0] rnd_sum;
  logic [80:0] shv;
  logic [48:0] lim;
  logic [48:0] mres;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= swme_pkg::MP_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    neg_r  <= neg_nxt;
    sh30_r <= sh30_nxt;
    wsel_r <= wsel_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
  end

  // one 32x32 multiplier serves both partial products
  assign mop = (ph_r == swme_pkg::MP_LO) ? a_r[31:0] : {16'd0, a_r[47:32]};
  assign pp  = mop * b_r;

  always_comb begin
    rnd_sum = {1'b0, acc_r} + (sh30_r ? (81'd1 << 29) : (81'd1 << 23));
    shv     = sh30_r ? (rnd_sum >> 30) : (rnd_sum >> 24);
    unique case (wsel_r)
      swme_pkg::SW_32: lim = (49'd1 << 31) - (neg_r ? 49'd0 : 49'd1);
      swme_pkg::SW_40: lim = (49'd1 << 39) - (neg_r ? 49'd0 : 49'd1);
      default:         lim = (49'd1 << 47) - (neg_r ? 49'd0 : 49'd1);
    endcase
    mres = (shv > 81'(lim)) ? lim : shv[48:0];
  end

  always_comb begin
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    neg_nxt  = neg_r;
    sh30_nxt = sh30_r;
    wsel_nxt = wsel_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    unique case (ph_r)
      swme_pkg::MP_IDLE: begin
        if (req.start) begin
          a_nxt    = req.a;
          b_nxt    = req.b;
          neg_nxt  = req.neg;
          sh30_nxt = req.sh30;
          wsel_nxt = req.wsel;
          ph_nxt   = swme_pkg::MP_LO;
        end
      end
      swme_pkg::MP_LO: begin
        acc_nxt = 80'(pp);
        ph_nxt  = swme_pkg::MP_HI;
      end
      swme_pkg::MP_HI: begin
        acc_nxt = acc_r + (80'(pp) << 32);
        ph_nxt  = swme_pkg::MP_RND;
      end
      default: begin
        res_nxt  = neg_r ? 48'(-mres) : mres[47:0];
        done_nxt = 1'b1;
        ph_nxt   = swme_pkg::MP_IDLE;
      end
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.busy = (ph_r != swme_pkg::MP_IDLE);
  assign rsp.res  = res_r;
  assign rsp.prod = acc_r[63:0];

endmodule

### rtl/swme_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a cycle: round(m*64/s), saturated at 2^40.
// Depends on swme_pkg.
module swme_div (
  input  logic               clk,
  input  logic               rst_n,
  input  swme_pkg::div_req_t req,
  output swme_pkg::div_rsp_t rsp
);

  swme_pkg::div_ph_t ph_r, ph_nxt;
  logic        done_r, done_nxt;
  logic [31:0] s_r, s_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [38:0] num_r, num_nxt;   // remaining dividend bits, MSB first
  logic [38:0] qsh_r, qsh_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [40:0] q_r, q_nxt;

  logic [32:0] rem_sh;
  logic        ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= swme_pkg::DP_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r   <= s_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    qsh_r <= qsh_nxt;
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
  end

  assign rem_sh = {rem_r, num_r[38]};
  assign ge     = (rem_sh >= {1'b0, s_r});

  always_comb begin
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    s_nxt    = s_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    qsh_nxt  = qsh_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    unique case (ph_r)
      swme_pkg::DP_IDLE: begin
        if (req.start) begin
          s_nxt   = req.s;
          rem_nxt = {2'd0, req.m[62:33]};
          num_nxt = {req.m[32:0], 6'd0};
          qsh_nxt = '0;
          cnt_nxt = 6'd38;
          if (req.m == '0) begin
            q_nxt    = '0;
            done_nxt = 1'b1;
          end else if ({2'd0, req.m[62:33]} >= req.s) begin
            // quotient would reach 2^39, also a zero scale
            q_nxt    = 41'd1 << 40;
            done_nxt = 1'b1;
          end else begin
            ph_nxt = swme_pkg::DP_RUN;
          end
        end
      end
      swme_pkg::DP_RUN: begin
        rem_nxt = ge ? 32'(rem_sh - {1'b0, s_r}) : rem_sh[31:0];
        qsh_nxt = {qsh_r[37:0], ge};
        num_nxt = {num_r[37:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          ph_nxt = swme_pkg::DP_RND;
        end
      end
      default: begin
        q_nxt    = 41'(qsh_r) + (({rem_r, 1'b0} >= {1'b0, s_r}) ? 41'd1 : 41'd0);
        done_nxt = 1'b1;
        ph_nxt   = swme_pkg::DP_IDLE;
      end
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.busy = (ph_r != swme_pkg::DP_IDLE);
  assign rsp.q    = q_r;

endmodule

### rtl/scaled_weight_matrix_engine_unit.sv
`timescale 1ns / 1ps
// Scaled weight matrix engine top level: sequencer, per-class state, output register.
// Depends on swme_pkg, swme_if, swme_ram, swme_mul, swme_div, assert_macros.svh.
//
//  channel | dir | handshake     | payload
//  in_if   | in  | valid / ready | mode, feature_index, feature_value, masked,
//          |     |               | class_sel, coeff, last_element
//  out_if  | out | valid / ready | score, class_index, last_score
//  cfg_if  | in  | valid / ready | index, data (ready held high)
//
// Work per item runs through the shared multiplier, the shared divider and the
// single weight RAM port:
//   score element one multiply per class, plus one more per class on the last element;
//   update-all element one multiply and one divide per class, update-one for its class only;
//   coefficient load, no arithmetic unit;
//   decay two multiplies per class, plus one per weight entry (DEPTH entries) when scales fold;
//   clear one write per weight entry (DEPTH entries).
// After reset a zeroing pass over all DEPTH entries runs with in_if.ready low.
// A stalled result only holds the sequencer when the next score has to be emitted.
`include "assert_macros.svh"

module scaled_weight_matrix_engine_unit (
  input  logic         clk,
  input  logic         rst_n,
  swme_in_if.sink      in_if,
  swme_out_if.source   out_if,
  swme_cfg_if.sink     cfg_if
);

  localparam int NC = swme_pkg::NUM_CLASSES;
  localparam int AW = swme_pkg::ADDR_W;
  localparam int CW = swme_pkg::CLS_W;

  // sequencer and loop counters
  swme_pkg::st_t st_r, st_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          fold_r, fold_nxt;

  // registers
  logic [31:0]        min_r, min_nxt;
  logic signed [31:0] bias_r, bias_nxt;

  // per-class state
  logic [31:0]        scale_r [NC];
  logic [31:0]        scale_nxt [NC];
  logic signed [47:0] icpt_r [NC];
  logic signed [47:0] icpt_nxt [NC];
  logic signed [47:0] acc_r [NC];
  logic signed [47:0] acc_nxt [NC];
  logic signed [31:0] coef_r [NC];
  logic signed [31:0] coef_nxt [NC];

  // latched item
  logic [swme_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [swme_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic signed [31:0]          val_r, val_nxt;
  logic                        use_r, use_nxt;
  logic [swme_pkg::SEL_W-1:0]  sel_r, sel_nxt;
  logic signed [31:0]          cin_r, cin_nxt;
  logic                        last_r, last_nxt;
  logic signed [47:0]          tmp_r, tmp_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic signed [47:0] score_r, score_nxt;
  logic [2:0]         cidx_r, cidx_nxt;
  logic               lscore_r, lscore_nxt;

  // RAM and shared units
  logic               ram_we, ram_re;
  logic signed [31:0] ram_wdata, rdata;
  swme_pkg::mul_req_t mreq;
  swme_pkg::mul_rsp_t mrsp;
  swme_pkg::div_req_t dreq;
  swme_pkg::div_rsp_t drsp;

  // helpers
  logic               in_acc;
  logic               single;
  logic               k_done;
  logic               sel_ok;
  logic signed [31:0] cur_c;
  logic               pneg;
  logic [AW-1:0]      row_base;
  logic signed [41:0] delta;
  logic [31:0]        new_scale;

  swme_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (addr_r),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  swme_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  swme_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign in_if.ready  = (st_r == swme_pkg::ST_IDLE);
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid       = out_valid_r;
  assign out_if.score       = score_r;
  assign out_if.class_index = cidx_r;
  assign out_if.last_score  = lscore_r;

  assign single   = (mode_r == swme_pkg::MD_UPD_ONE);
  assign k_done   = single || (k_r == swme_pkg::K_LAST);
  assign sel_ok   = ({1'b0, sel_r} < 4'(NC));
  assign cur_c    = single ? cin_r : coef_r[k_r];
  assign pneg     = val_r[31] ^ cur_c[31];
  assign row_base = AW'(row_r) * AW'(NC);
  assign delta    = pneg ? 42'(-$signed({1'b0, drsp.q})) : 42'($signed({1'b0, drsp.q}));

  // decayed scale clamped to the unsigned 32-bit range
  always_comb begin
    if (mrsp.res[47]) begin
      new_scale = '0;
    end else if (mrsp.res[46:32] != '0) begin
      new_scale = 32'hFFFF_FFFF;
    end else begin
      new_scale = mrsp.res[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= swme_pkg::ST_CLEAR;
      k_r         <= '0;
      addr_r      <= '0;
      fold_r      <= 1'b0;
      out_valid_r <= 1'b0;
      min_r       <= swme_pkg::MIN_SCALE_RST;
      bias_r      <= swme_pkg::BIAS_RST;
      for (int i = 0; i < NC; i++) begin
        scale_r[i] <= swme_pkg::SCALE_ONE;
        icpt_r[i]  <= '0;
        acc_r[i]   <= '0;
        coef_r[i]  <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      k_r         <= k_nxt;
      addr_r      <= addr_nxt;
      fold_r      <= fold_nxt;
      out_valid_r <= out_valid_nxt;
      min_r       <= min_nxt;
      bias_r      <= bias_nxt;
      scale_r     <= scale_nxt;
      icpt_r      <= icpt_nxt;
      acc_r       <= acc_nxt;
      coef_r      <= coef_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    row_r    <= row_nxt;
    val_r    <= val_nxt;
    use_r    <= use_nxt;
    sel_r    <= sel_nxt;
    cin_r    <= cin_nxt;
    last_r   <= last_nxt;
    tmp_r    <= tmp_nxt;
    score_r  <= score_nxt;
    cidx_r   <= cidx_nxt;
    lscore_r <= lscore_nxt;
  end

  always_comb begin
    st_nxt        = st_r;
    k_nxt         = k_r;
    addr_nxt      = addr_r;
    fold_nxt      = fold_r;
    min_nxt       = min_r;
    bias_nxt      = bias_r;
    scale_nxt     = scale_r;
    icpt_nxt      = icpt_r;
    acc_nxt       = acc_r;
    coef_nxt      = coef_r;
    mode_nxt      = mode_r;
    row_nxt       = row_r;
    val_nxt       = val_r;
    use_nxt       = use_r;
    sel_nxt       = sel_r;
    cin_nxt       = cin_r;
    last_nxt      = last_r;
    tmp_nxt       = tmp_r;
    score_nxt     = score_r;
    cidx_nxt      = cidx_r;
    lscore_nxt    = lscore_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = '0;
    mreq          = '0;
    dreq          = '0;

    // register writes
    if (cfg_if.valid) begin
      if (cfg_if.index == swme_pkg::REG_MIN_SCALE) begin
        min_nxt = cfg_if.data;
      end else if (cfg_if.index == swme_pkg::REG_BIAS_VALUE) begin
        bias_nxt = $signed(cfg_if.data);
      end
    end

    unique case (st_r)
      swme_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (addr_r == swme_pkg::ADDR_END) begin
          st_nxt = swme_pkg::ST_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end

      swme_pkg::ST_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_if.mode;
          row_nxt  = in_if.feature_index;
          val_nxt  = in_if.feature_value;
          use_nxt  = !in_if.masked &&
                     ({1'b0, in_if.feature_index} < (swme_pkg::ROW_W + 1)'(swme_pkg::NUM_DIMS));
          sel_nxt  = in_if.class_sel;
          cin_nxt  = in_if.coeff;
          last_nxt = in_if.last_element;
          st_nxt   = swme_pkg::ST_DISP;
        end
      end

      swme_pkg::ST_DISP: begin
        st_nxt = swme_pkg::ST_IDLE;
        k_nxt  = '0;
        unique case (mode_r)
          swme_pkg::MD_SCORE: begin
            addr_nxt = row_base;
            if (use_r) begin
              st_nxt = swme_pkg::ST_SC_RD;
            end else if (last_r) begin
              st_nxt = swme_pkg::ST_SO_MUL;
            end
          end
          swme_pkg::MD_UPD_ALL: begin
            addr_nxt = row_base;
            if (use_r) begin
              st_nxt = swme_pkg::ST_UP_RD;
            end else if (last_r) begin
              st_nxt = swme_pkg::ST_IC_MUL;
            end
          end
          swme_pkg::MD_UPD_ONE: begin
            // bad class: nothing happens
            if (sel_ok) begin
              k_nxt    = CW'(sel_r);
              addr_nxt = row_base + AW'(sel_r);
              if (use_r) begin
                st_nxt = swme_pkg::ST_UP_RD;
              end else if (last_r) begin
                st_nxt = swme_pkg::ST_IC_MUL;
              end
            end
          end
          swme_pkg::MD_SET_COEF: begin
            if (sel_ok) begin
              coef_nxt[CW'(sel_r)] = cin_r;
            end
          end
          swme_pkg::MD_DECAY: begin
            fold_nxt = 1'b0;
            st_nxt   = swme_pkg::ST_DC_SMUL;
          end
          swme_pkg::MD_CLEAR: begin
            for (int i = 0; i < NC; i++) begin
              scale_nxt[i] = swme_pkg::SCALE_ONE;
              icpt_nxt[i]  = '0;
            end
            addr_nxt = '0;
            st_nxt   = swme_pkg::ST_CLEAR;
          end
          default: begin
            st_nxt = swme_pkg::ST_IDLE;
          end
        endcase
      end

      // score: accumulate value * weight per class
      swme_pkg::ST_SC_RD: begin
        ram_re = 1'b1;
        st_nxt = swme_pkg::ST_SC_MUL;
      end
      swme_pkg::ST_SC_MUL: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(swme_pkg::mag32(val_r));
        mreq.b     = swme_pkg::mag32(rdata);
        mreq.neg   = val_r[31] ^ rdata[31];
        mreq.sh30  = 1'b0;
        mreq.wsel  = swme_pkg::SW_48;
        st_nxt     = swme_pkg::ST_SC_ACC;
      end
      swme_pkg::ST_SC_ACC: begin
        if (mrsp.done) begin
          acc_nxt[k_r] = swme_pkg::sat_add48(acc_r[k_r], mrsp.res);
          if (k_r == swme_pkg::K_LAST) begin
            k_nxt  = '0;
            st_nxt = last_r ? swme_pkg::ST_SO_MUL : swme_pkg::ST_IDLE;
          end else begin
            k_nxt    = k_r + CW'(1);
            addr_nxt = addr_r + AW'(1);
            st_nxt   = swme_pkg::ST_SC_RD;
          end
        end
      end

      // score output: accum * scale + intercept, one result per class
      swme_pkg::ST_SO_MUL: begin
        mreq.start = 1'b1;
        mreq.a     = swme_pkg::mag48(acc_r[k_r]);
        mreq.b     = scale_r[k_r];
        mreq.neg   = acc_r[k_r][47];
        mreq.sh30  = 1'b1;
        mreq.wsel  = swme_pkg::SW_48;
        st_nxt     = swme_pkg::ST_SO_WAIT;
      end
      swme_pkg::ST_SO_WAIT: begin
        if (mrsp.done) begin
          tmp_nxt = swme_pkg::sat_add48(mrsp.res, icpt_r[k_r]);
          st_nxt  = swme_pkg::ST_SO_EMIT;
        end
      end
      swme_pkg::ST_SO_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          score_nxt     = tmp_r;
          cidx_nxt      = 3'(k_r);
          lscore_nxt    = (k_r == swme_pkg::K_LAST);
          acc_nxt[k_r]  = '0;
          if (k_r == swme_pkg::K_LAST) begin
            st_nxt = swme_pkg::ST_IDLE;
          end else begin
            k_nxt  = k_r + CW'(1);
            st_nxt = swme_pkg::ST_SO_MUL;
          end
        end
      end

      // update: weight += round(value * coeff * 64 / scale)
      swme_pkg::ST_UP_RD: begin
        ram_re = 1'b1;
        st_nxt = swme_pkg::ST_UP_MUL;
      end
      swme_pkg::ST_UP_MUL: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(swme_pkg::mag32(val_r));
        mreq.b     = swme_pkg::mag32(cur_c);
        mreq.neg   = pneg;
        mreq.sh30  = 1'b0;
        mreq.wsel  = swme_pkg::SW_48;
        st_nxt     = swme_pkg::ST_UP_PROD;
      end
      swme_pkg::ST_UP_PROD: begin
        if (mrsp.done) begin
          dreq.start = 1'b1;
          dreq.m     = mrsp.prod[62:0];
          dreq.s     = scale_r[k_r];
          st_nxt     = swme_pkg::ST_UP_DIV;
        end
      end
      swme_pkg::ST_UP_DIV: begin
        if (drsp.done) begin
          ram_we    = 1'b1;
          ram_wdata = swme_pkg::sat_w32(43'(rdata) + 43'(delta));
          if (k_done) begin
            if (!single) begin
              k_nxt = '0;
            end
            st_nxt = last_r ? swme_pkg::ST_IC_MUL : swme_pkg::ST_IDLE;
          end else begin
            k_nxt    = k_r + CW'(1);
            addr_nxt = addr_r + AW'(1);
            st_nxt   = swme_pkg::ST_UP_RD;
          end
        end
      end

      // intercept += bias * coeff
      swme_pkg::ST_IC_MUL: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(swme_pkg::mag32(bias_r));
        mreq.b     = swme_pkg::mag32(cur_c);
        mreq.neg   = bias_r[31] ^ cur_c[31];
        mreq.sh30  = 1'b0;
        mreq.wsel  = swme_pkg::SW_48;
        st_nxt     = swme_pkg::ST_IC_WAIT;
      end
      swme_pkg::ST_IC_WAIT: begin
        if (mrsp.done) begin
          icpt_nxt[k_r] = swme_pkg::sat_add48(icpt_r[k_r], mrsp.res);
          if (k_done) begin
            st_nxt = swme_pkg::ST_IDLE;
          end else begin
            k_nxt  = k_r + CW'(1);
            st_nxt = swme_pkg::ST_IC_MUL;
          end
        end
      end

      // decay: scale and intercept times coefficient
      swme_pkg::ST_DC_SMUL: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(scale_r[k_r]);
        mreq.b     = swme_pkg::mag32(coef_r[k_r]);
        mreq.neg   = coef_r[k_r][31];
        mreq.sh30  = 1'b0;
        mreq.wsel  = swme_pkg::SW_40;
        st_nxt     = swme_pkg::ST_DC_SWAIT;
      end
      swme_pkg::ST_DC_SWAIT: begin
        if (mrsp.done) begin
          scale_nxt[k_r] = new_scale;
          if (new_scale < min_r) begin
            fold_nxt = 1'b1;
          end
          st_nxt = swme_pkg::ST_DC_IMUL;
        end
      end
      swme_pkg::ST_DC_IMUL: begin
        mreq.start = 1'b1;
        mreq.a     = swme_pkg::mag48(icpt_r[k_r]);
        mreq.b     = swme_pkg::mag32(coef_r[k_r]);
        mreq.neg   = icpt_r[k_r][47] ^ coef_r[k_r][31];
        mreq.sh30  = 1'b0;
        mreq.wsel  = swme_pkg::SW_48;
        st_nxt     = swme_pkg::ST_DC_IWAIT;
      end
      swme_pkg::ST_DC_IWAIT: begin
        if (mrsp.done) begin
          icpt_nxt[k_r] = mrsp.res;
          if (k_r == swme_pkg::K_LAST) begin
            k_nxt    = '0;
            addr_nxt = '0;
            st_nxt   = fold_r ? swme_pkg::ST_FD_RD : swme_pkg::ST_IDLE;
          end else begin
            k_nxt  = k_r + CW'(1);
            st_nxt = swme_pkg::ST_DC_SMUL;
          end
        end
      end

      // fold: every weight times the scale of its class, k tracks addr mod classes
      swme_pkg::ST_FD_RD: begin
        ram_re = 1'b1;
        st_nxt = swme_pkg::ST_FD_MUL;
      end
      swme_pkg::ST_FD_MUL: begin
        mreq.start = 1'b1;
        mreq.a     = 48'(swme_pkg::mag32(rdata));
        mreq.b     = scale_r[k_r];
        mreq.neg   = rdata[31];
        mreq.sh30  = 1'b1;
        mreq.wsel  = swme_pkg::SW_32;
        st_nxt     = swme_pkg::ST_FD_WAIT;
      end
      swme_pkg::ST_FD_WAIT: begin
        if (mrsp.done) begin
          ram_we    = 1'b1;
          ram_wdata = mrsp.res[31:0];
          if (addr_r == swme_pkg::ADDR_END) begin
            for (int i = 0; i < NC; i++) begin
              scale_nxt[i] = swme_pkg::SCALE_ONE;
            end
            st_nxt = swme_pkg::ST_IDLE;
          end else begin
            addr_nxt = addr_r + AW'(1);
            k_nxt    = (k_r == swme_pkg::K_LAST) ? '0 : k_r + CW'(1);
            st_nxt   = swme_pkg::ST_FD_RD;
          end
        end
      end

      default: begin
        st_nxt = swme_pkg::ST_IDLE;
      end
    endcase
  end

  // ready only with both arithmetic units quiet
  `SWME_ASSERT(a_idle_units, in_if.ready |-> (!mrsp.busy && !drsp.busy), "ready while busy")
  // an accepted item always drops ready for the next cycle
  `SWME_ASSERT(a_accept_busy, in_acc |=> !in_if.ready, "ready held after accept")
  // no weight write while waiting for an item
  `SWME_ASSERT(a_idle_no_write, (st_r == swme_pkg::ST_IDLE) |-> !ram_we, "RAM write in idle")
  // the final-class flag only on the top class
  `SWME_ASSERT(a_last_class, (out_valid_r && lscore_r) |-> (cidx_r == 3'(swme_pkg::K_LAST)),
               "last score on wrong class")
  // the zeroing pass runs straight after reset
  `SWME_ASSERT_ALWAYS(a_reset_clear, !$past(rst_n) |-> (st_r == swme_pkg::ST_CLEAR),
                      "no clear pass after reset")

endmodule
